// File: src/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 4;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 5;

    localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd9;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BADPRIO = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        prio;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry item;
    } t_ctl;

endpackage

// File: src/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  t_ctl   i_ctl,
    input  logic   i_occ,
    input  logic   i_left_keep,
    input  t_entry i_left,
    input  t_entry i_right,
    output logic   o_keep,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_keep  = i_occ && (r_entry.prio >= i_ctl.item.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? i_ctl.item : i_left;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: src/sorted_priority_queue.sv
// Sorted priority queue: a row of DEPTH slots kept in order, highest priority
// at the head and ties in arrival order. Each transaction is an insert or a
// remove and yields one result in the cycle after it is accepted. The queue
// takes one transaction per clock as long as results are taken; the row of
// slots compares and shifts in the accepting cycle, so the only wait is a
// stalled result register. Inserts into a full queue or with priority outside
// 1..9 are rejected with a status; removes from an empty queue return zeros.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps

module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic signed [DATA_W-1:0] i_data_in,
    input  logic [PRIO_W-1:0]        i_prio_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_data_out,
    output logic [PRIO_W-1:0]        o_prio_out,
    output logic [FILL_W-1:0]        o_fill
);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [PRIO_W-1:0]  r_prio;
    logic [PRIO_W-1:0]  n_prio;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_prio_ok;
    t_ctl               w_ctl;
    logic [DEPTH-1:0]   w_occ;
    logic [DEPTH-1:0]   w_keep;
    t_entry             w_entry [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_prio_ok  = (i_prio_in >= PRIO_MIN) && (i_prio_in <= PRIO_MAX);

    assign w_ctl.ins       = w_accept && (i_op == OP_INSERT) && !w_full && w_prio_ok;
    assign w_ctl.rem       = w_accept && (i_op == OP_REMOVE) && !w_empty;
    assign w_ctl.item.data = i_data_in;
    assign w_ctl.item.prio = i_prio_in;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_keep;

            assign w_occ[gi] = (r_count > CNT_W'(gi));

            if (gi == 0) begin : g_head
                assign w_left      = '0;
                assign w_left_keep = 1'b1;
            end else begin : g_body
                assign w_left      = w_entry[gi-1];
                assign w_left_keep = w_keep[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_entry[gi+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[gi]),
                .i_left_keep (w_left_keep),
                .i_left      (w_left),
                .i_right     (w_right),
                .o_keep      (w_keep[gi]),
                .o_entry     (w_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_data   = '0;
        n_prio   = '0;
        if (i_op == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else if (!w_prio_ok) begin
                n_status = ST_BADPRIO;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_data  = w_entry[0].data;
                n_prio  = w_entry[0].prio;
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_prio   <= n_prio;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data_out  = r_data;
    assign o_prio_out  = r_prio;
    assign o_fill      = FILL_W'(r_count);

endmodule

// File: src/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_macros.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_checker
    import spq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [STAT_W-1:0]        o_status,
    input logic signed [DATA_W-1:0] o_data_out,
    input logic [PRIO_W-1:0]        o_prio_out,
    input logic [FILL_W-1:0]        o_fill
);

    `SPQ_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_status) && $stable(o_data_out) &&
        $stable(o_prio_out) && $stable(o_fill),
        "stalled result changed")
    `SPQ_ASSERT_IMP(a_stall_cause, o_in_stall, o_out_valid && i_out_stall,
        "input stalled without a waiting result")
    `SPQ_ASSERT_IMP(a_fail_zero, o_out_valid && (o_status != ST_OK),
        (o_data_out == '0) && (o_prio_out == '0), "failed transaction returned data")
    `SPQ_ASSERT_IMP(a_prio_range, o_out_valid && (o_prio_out != '0),
        (o_status == ST_OK) && (o_prio_out >= PRIO_MIN) && (o_prio_out <= PRIO_MAX),
        "removed priority out of range")
    `SPQ_ASSERT_IMP(a_empty_fill, o_out_valid && (o_status == ST_EMPTY), o_fill == '0,
        "empty status with entries held")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
